// ----- rtl/core/rigid_transform_quaternion_core_defines.svh -----
`ifndef RIGID_TRANSFORM_QUATERNION_CORE_DEFINES_SVH
`define RIGID_TRANSFORM_QUATERNION_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RTQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RTQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RTQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rtq_pkg.sv -----
package rtq_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int SC_W  = 31;
  localparam int R_W   = 41;
  localparam int NUM_W = 57;
  localparam int VAL_W = NUM_W + 1;

  localparam logic [1:0] MODE_FWD_PT  = 2'd0;
  localparam logic [1:0] MODE_FWD_DIR = 2'd1;
  localparam logic [1:0] MODE_BWD_PT  = 2'd2;
  localparam logic [1:0] MODE_BWD_DIR = 2'd3;

  localparam logic [2:0] REG_ROT_X   = 3'd0;
  localparam logic [2:0] REG_ROT_Y   = 3'd1;
  localparam logic [2:0] REG_ROT_Z   = 3'd2;
  localparam logic [2:0] REG_ROT_W   = 3'd3;
  localparam logic [2:0] REG_TRANS_X = 3'd4;
  localparam logic [2:0] REG_TRANS_Y = 3'd5;
  localparam logic [2:0] REG_TRANS_Z = 3'd6;
  localparam logic [2:0] REG_SCALE   = 3'd7;

  typedef struct packed {
    logic                  divide;
    logic                  neg;
    logic                  flag;
    logic signed [R_W-1:0] r;
  } rtq_tag_t;

endpackage

// ----- rtl/core/rtq_div.sv -----
`include "rigid_transform_quaternion_core_defines.svh"

module rtq_div #(
  parameter int NUM_W = rtq_pkg::NUM_W,
  parameter int DIV_W = rtq_pkg::SC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  rtq_pkg::rtq_tag_t in_tag,
  input  logic [DIV_W-1:0] div,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quot,
  output rtq_pkg::rtq_tag_t out_tag
);

  // one quotient bit per stage; numerator shifts out as quotient shifts in
  logic             vld [NUM_W];
  logic [DIV_W-1:0] rem [NUM_W];
  logic [NUM_W-1:0] nq  [NUM_W];
  rtq_pkg::rtq_tag_t tag [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_in;
    logic [DIV_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    rtq_pkg::rtq_tag_t tag_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign nq_in  = in_num;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign rem_in = rem[k-1];
      assign nq_in  = nq[k-1];
      assign tag_in = tag[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, div};
    assign ge    = trial >= {1'b0, div};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      rem[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      nq[k]  <= {nq_in[NUM_W-2:0], ge};
      tag[k] <= tag_in;
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign out_quot  = nq[NUM_W-1];
  assign out_tag   = tag[NUM_W-1];

  `RTQ_ASSERT_IMP(a_rem_below_div, clk, rst, vld[NUM_W-1], rem[NUM_W-1] < div, "remainder not below divisor")
  `RTQ_ASSERT_IMP(a_div_latency, clk, rst, out_valid, $past(in_valid, NUM_W), "divider output without input")

endmodule

// ----- rtl/core/rigid_transform_quaternion_core.sv -----
// Scale, quaternion rotation and translation of Q16.16 vectors, forward or
// backward. A transaction is taken on every cycle that start is high; busy is
// never raised. Each result appears on out_x/out_y/out_z/saturated for one
// cycle with done high, after passing stages 1 to 7, the one-bit-per-stage
// divider (which divides only for backward points), stage 8 and the final clip.
// The receiver cannot stall, so results must be taken when done is high.
// Configuration may be written only while no transaction is in flight.
`include "rigid_transform_quaternion_core_defines.svh"

module rigid_transform_quaternion_core #(
  parameter int COORD_WIDTH = rtq_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               saturated
);

  localparam int NUM_W = rtq_pkg::NUM_W;
  localparam int R_W   = rtq_pkg::R_W;
  localparam int VAL_W = rtq_pkg::VAL_W;
  localparam int SC_W  = rtq_pkg::SC_W;
  localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int LAT   = NUM_W + 9;

  localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
  localparam logic signed [64:0] T_LIM = 65'sd4294967295;
  localparam logic signed [VAL_W-1:0] HI = (VAL_W'(1) <<< (SAT_W - 1)) - VAL_W'(1);
  localparam logic signed [VAL_W-1:0] LO = -(VAL_W'(1) <<< (SAT_W - 1));

  // configuration
  logic signed [31:0] rot [4];
  logic signed [31:0] trans [3];
  logic [SC_W-1:0]    scale;
  logic [SC_W-1:0]    divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= '0;
      rot[1] <= '0;
      rot[2] <= '0;
      rot[3] <= Q_ONE;
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
      scale <= SC_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        rtq_pkg::REG_ROT_X:   rot[0] <= cfg_data;
        rtq_pkg::REG_ROT_Y:   rot[1] <= cfg_data;
        rtq_pkg::REG_ROT_Z:   rot[2] <= cfg_data;
        rtq_pkg::REG_ROT_W:   rot[3] <= cfg_data;
        rtq_pkg::REG_TRANS_X: trans[0] <= cfg_data;
        rtq_pkg::REG_TRANS_Y: trans[1] <= cfg_data;
        rtq_pkg::REG_TRANS_Z: trans[2] <= cfg_data;
        rtq_pkg::REG_SCALE:   scale <= cfg_data[SC_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor = (scale == '0) ? SC_W'(1) : scale;
  assign busy = 1'b0;

  // clamped quaternion, plain and conjugate
  logic signed [31:0] qc [4];
  logic signed [31:0] qp [4];
  logic signed [31:0] qn [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (rot[i] > Q_ONE) begin
        qc[i] = Q_ONE;
      end else if (rot[i] < -Q_ONE) begin
        qc[i] = -Q_ONE;
      end else begin
        qc[i] = rot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) qp[i] <= qc[i];
    for (int i = 0; i < 3; i++) qn[i] <= -qc[i];
  end

  logic signed [31:0] vin [3];
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  // stage 1: scale product, translation difference
  logic               s1_vld;
  logic [1:0]         s1_mode;
  logic signed [63:0] s1_p [3];
  logic signed [32:0] s1_a [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    s1_mode <= req_type;
    for (int i = 0; i < 3; i++) begin
      s1_p[i] <= $signed({1'b0, scale}) * vin[i];
      if (req_type == rtq_pkg::MODE_BWD_PT) begin
        s1_a[i] <= 33'(vin[i]) - 33'(trans[i]);
      end else begin
        s1_a[i] <= 33'(vin[i]);
      end
    end
  end

  // stage 2: round and clip the prepared vector
  logic signed [63:0] rnd2 [3];
  logic signed [31:0] v2 [3];
  logic               f2;

  always_comb begin
    f2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd2[i] = (s1_p[i] + 64'sd32768) >>> 16;
      case (s1_mode)
        rtq_pkg::MODE_FWD_PT: begin
          if (rnd2[i] > I32_MAX) begin
            v2[i] = 32'sh7fff_ffff;
            f2 = 1'b1;
          end else if (rnd2[i] < I32_MIN) begin
            v2[i] = 32'sh8000_0000;
            f2 = 1'b1;
          end else begin
            v2[i] = rnd2[i][31:0];
          end
        end
        rtq_pkg::MODE_BWD_PT: begin
          if (64'(s1_a[i]) > I32_MAX) begin
            v2[i] = 32'sh7fff_ffff;
            f2 = 1'b1;
          end else if (64'(s1_a[i]) < I32_MIN) begin
            v2[i] = 32'sh8000_0000;
            f2 = 1'b1;
          end else begin
            v2[i] = s1_a[i][31:0];
          end
        end
        default: v2[i] = s1_a[i][31:0];
      endcase
    end
  end

  logic               s2_vld;
  logic [1:0]         s2_mode;
  logic               s2_flag;
  logic signed [31:0] s2_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_mode <= s1_mode;
    s2_flag <= f2;
    for (int i = 0; i < 3; i++) s2_v[i] <= v2[i];
  end

  // stage 3: q x v partial products
  logic signed [31:0] q3 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) q3[i] = s2_mode[1] ? qn[i] : qp[i];
  end

  logic               s3_vld;
  logic [1:0]         s3_mode;
  logic               s3_flag;
  logic signed [31:0] s3_v [3];
  logic signed [63:0] s3_pa [3];
  logic signed [63:0] s3_pb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_mode <= s2_mode;
    s3_flag <= s2_flag;
    for (int i = 0; i < 3; i++) begin
      s3_v[i]  <= s2_v[i];
      s3_pa[i] <= q3[(i + 1) % 3] * s2_v[(i + 2) % 3];
      s3_pb[i] <= q3[(i + 2) % 3] * s2_v[(i + 1) % 3];
    end
  end

  // stage 4: t = round(q x v), clipped
  logic signed [64:0] c4 [3];
  logic signed [64:0] sh4 [3];
  logic signed [33:0] t4 [3];
  logic               f4;

  always_comb begin
    f4 = s3_flag;
    for (int i = 0; i < 3; i++) begin
      c4[i]  = 65'(s3_pa[i]) - 65'(s3_pb[i]);
      sh4[i] = (c4[i] + 65'sd536870912) >>> 30;
      if (sh4[i] > T_LIM) begin
        t4[i] = T_LIM[33:0];
        f4 = 1'b1;
      end else if (sh4[i] < -T_LIM) begin
        t4[i] = -(T_LIM[33:0]);
        f4 = 1'b1;
      end else begin
        t4[i] = sh4[i][33:0];
      end
    end
  end

  logic               s4_vld;
  logic [1:0]         s4_mode;
  logic               s4_flag;
  logic signed [31:0] s4_v [3];
  logic signed [33:0] s4_t [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_mode <= s3_mode;
    s4_flag <= f4;
    for (int i = 0; i < 3; i++) begin
      s4_v[i] <= s3_v[i];
      s4_t[i] <= t4[i];
    end
  end

  // stage 5: qw*t and q x t partial products
  logic signed [31:0] q5 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) q5[i] = s4_mode[1] ? qn[i] : qp[i];
  end

  logic               s5_vld;
  logic [1:0]         s5_mode;
  logic               s5_flag;
  logic signed [31:0] s5_v [3];
  logic signed [65:0] s5_pw [3];
  logic signed [65:0] s5_ca [3];
  logic signed [65:0] s5_cb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_mode <= s4_mode;
    s5_flag <= s4_flag;
    for (int i = 0; i < 3; i++) begin
      s5_v[i]  <= s4_v[i];
      s5_pw[i] <= qp[3] * s4_t[i];
      s5_ca[i] <= q5[(i + 1) % 3] * s4_t[(i + 2) % 3];
      s5_cb[i] <= q5[(i + 2) % 3] * s4_t[(i + 1) % 3];
    end
  end

  // stage 6: r = v + 2d
  logic signed [66:0] w6 [3];
  logic signed [66:0] x6 [3];
  logic signed [66:0] r6 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w6[i] = (67'(s5_pw[i]) + 67'sd536870912) >>> 30;
      x6[i] = (67'(s5_ca[i]) - 67'(s5_cb[i]) + 67'sd536870912) >>> 30;
      r6[i] = 67'(s5_v[i]) + ((w6[i] + x6[i]) <<< 1);
    end
  end

  logic                  s6_vld;
  logic [1:0]            s6_mode;
  logic                  s6_flag;
  logic signed [R_W-1:0] s6_r [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_mode <= s5_mode;
    s6_flag <= s5_flag;
    for (int i = 0; i < 3; i++) s6_r[i] <= r6[i][R_W-1:0];
  end

  // stage 7: translate, or form the rounded division numerator
  logic                  s7_vld;
  logic [NUM_W-1:0]      s7_num [3];
  rtq_pkg::rtq_tag_t     s7_tag [3];
  logic signed [R_W-1:0] m7 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) m7[i] = s6_r[i][R_W-1] ? -s6_r[i] : s6_r[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s7_num[i] <= NUM_W'({m7[i][R_W-2:0], 16'b0}) + NUM_W'(divisor >> 1);
      s7_tag[i].divide <= (s6_mode == rtq_pkg::MODE_BWD_PT);
      s7_tag[i].neg    <= s6_r[i][R_W-1];
      s7_tag[i].flag   <= s6_flag;
      if (s6_mode == rtq_pkg::MODE_FWD_PT) begin
        s7_tag[i].r <= s6_r[i] + R_W'(trans[i]);
      end else begin
        s7_tag[i].r <= s6_r[i];
      end
    end
  end

  logic              d_vld [3];
  logic [NUM_W-1:0]  d_quot [3];
  rtq_pkg::rtq_tag_t d_tag [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rtq_div #(
      .NUM_W (NUM_W),
      .DIV_W (SC_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s7_vld),
      .in_num    (s7_num[g]),
      .in_tag    (s7_tag[g]),
      .div       (divisor),
      .out_valid (d_vld[g]),
      .out_quot  (d_quot[g]),
      .out_tag   (d_tag[g])
    );
  end

  // stage 8: pick the value
  logic                    s8_vld;
  logic                    s8_flag;
  logic signed [VAL_W-1:0] s8_val [3];
  logic signed [VAL_W-1:0] qs8 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) qs8[i] = $signed({1'b0, d_quot[i]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= d_vld[0] & d_vld[1] & d_vld[2];
    end
    s8_flag <= d_tag[0].flag | d_tag[1].flag | d_tag[2].flag;
    for (int i = 0; i < 3; i++) begin
      if (d_tag[i].divide) begin
        s8_val[i] <= d_tag[i].neg ? -qs8[i] : qs8[i];
      end else begin
        s8_val[i] <= VAL_W'(d_tag[i].r);
      end
    end
  end

  // stage 9: final clip
  logic signed [VAL_W-1:0] c9 [3];
  logic                    f9;

  always_comb begin
    f9 = s8_flag;
    for (int i = 0; i < 3; i++) begin
      if (s8_val[i] > HI) begin
        c9[i] = HI;
        f9 = 1'b1;
      end else if (s8_val[i] < LO) begin
        c9[i] = LO;
        f9 = 1'b1;
      end else begin
        c9[i] = s8_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8_vld;
    end
    out_x     <= c9[0][31:0];
    out_y     <= c9[1][31:0];
    out_z     <= c9[2][31:0];
    saturated <= f9;
  end

  `RTQ_ASSERT_IMP(a_done_latency, clk, rst, done, $past(start, LAT), "result without matching transaction")

endmodule
